>>> rtl/rrs_pkg.sv
package rrs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int PID_W   = 8;
    localparam int BURST_W = 12;
    localparam int TIME_W  = 32;
    localparam int COST_W  = 8;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 144;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_TIME_SLICE   = 2'd0;
    localparam logic [1:0] REG_SWITCH_COST  = 2'd1;
    localparam logic [1:0] REG_RESTART_COST = 2'd2;

    localparam logic [COST_W-1:0] RST_TIME_SLICE   = 8'd2;
    localparam logic [COST_W-1:0] RST_SWITCH_COST  = 8'd0;
    localparam logic [COST_W-1:0] RST_RESTART_COST = 8'd7;

    localparam logic MODE_ADMIT = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic capture;
        logic load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic [COST_W-1:0] time_slice;
        logic [COST_W-1:0] switch_cost;
        logic [COST_W-1:0] restart_cost;
    } t_cfg;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/rrs_cfg_regs.sv
module rrs_cfg_regs
    import rrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic wr_en;
    logic [1:0] reg_idx;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign reg_idx  = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_slice   <= RST_TIME_SLICE;
            r_cfg.switch_cost  <= RST_SWITCH_COST;
            r_cfg.restart_cost <= RST_RESTART_COST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TIME_SLICE:   r_cfg.time_slice   <= i_pwdata[COST_W-1:0];
                REG_SWITCH_COST:  r_cfg.switch_cost  <= i_pwdata[COST_W-1:0];
                REG_RESTART_COST: r_cfg.restart_cost <= i_pwdata[COST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TIME_SLICE:   o_prdata = APB_DATA_W'(r_cfg.time_slice);
            REG_SWITCH_COST:  o_prdata = APB_DATA_W'(r_cfg.switch_cost);
            REG_RESTART_COST: o_prdata = APB_DATA_W'(r_cfg.restart_cost);
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/rrs_ctrl.sv
module rrs_ctrl
    import rrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_CALC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_CALC;
            end
            S_CALC: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/rrs_dp.sv
module rrs_dp
    import rrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_cfg                  i_cfg,
    input  logic [IN_DATA_W-1:0]  i_data,
    input  logic                  i_mode,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic [PID_W-1:0]   r_job_ids     [QUEUE_DEPTH];
    logic [BURST_W-1:0] r_job_bursts  [QUEUE_DEPTH];
    logic [BURST_W-1:0] r_job_rem     [QUEUE_DEPTH];
    logic [TIME_W-1:0]  r_job_arr     [QUEUE_DEPTH];
    logic               r_job_seen    [QUEUE_DEPTH];

    logic [PTR_W-1:0]  r_head, r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [COST_W-1:0] r_slice;
    logic [TIME_W-1:0] r_time;
    logic              r_restart_pend;

    logic               r_mode;
    logic [PID_W-1:0]   r_in_pid;
    logic [BURST_W-1:0] r_in_burst;
    logic [TIME_W-1:0]  r_in_arr;

    logic               r_busy, r_full;
    logic [PID_W-1:0]   r_h_id;
    logic [BURST_W-1:0] r_h_burst, r_h_rem;
    logic [TIME_W-1:0]  r_h_arr, r_h_sum, r_t1;
    logic               r_h_seen;

    logic [OUT_DATA_W-1:0] r_out;

    logic [BURST_W-1:0] rem_new;
    logic [COST_W-1:0]  slice_new;
    logic               done, rotate, last_job;
    logic [COST_W-1:0]  cost;
    logic [TIME_W-1:0]  resp, ta, wait_t, time_new;
    logic               we;
    logic [PTR_W-1:0]   w_addr;
    logic [PID_W-1:0]   w_id;
    logic [BURST_W-1:0] w_burst, w_rem;
    logic [TIME_W-1:0]  w_arr;
    logic               w_seen;
    logic [OUT_DATA_W-1:0] n_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i_mode;
            r_in_pid   <= i_data[7:0];
            r_in_burst <= i_data[19:8];
            r_in_arr   <= i_data[51:20];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_busy    <= (r_count != '0);
            r_full    <= (r_count == CNT_W'(QUEUE_DEPTH));
            r_h_id    <= r_job_ids[r_head];
            r_h_burst <= r_job_bursts[r_head];
            r_h_rem   <= r_job_rem[r_head];
            r_h_arr   <= r_job_arr[r_head];
            r_h_seen  <= r_job_seen[r_head];
            r_h_sum   <= r_job_arr[r_head] + TIME_W'(r_job_bursts[r_head]);
            if (r_count != '0 && r_restart_pend) begin
                r_t1 <= r_time + TIME_W'(i_cfg.restart_cost);
            end else begin
                r_t1 <= r_time;
            end
        end
    end

    always_comb begin
        rem_new   = (r_h_rem == '0) ? '0 : r_h_rem - BURST_W'(1);
        slice_new = r_slice + COST_W'(1);
        done      = (rem_new == '0);
        rotate    = !done && (slice_new == i_cfg.time_slice);
        last_job  = (r_count == CNT_W'(1));
        resp      = r_t1 - r_h_arr;
        ta        = r_t1 - r_h_arr + TIME_W'(1);
        wait_t    = r_t1 - r_h_sum + TIME_W'(1);

        priority if (done) begin
            cost = last_job ? i_cfg.restart_cost : i_cfg.switch_cost;
        end else if (rotate) begin
            cost = i_cfg.switch_cost;
        end else begin
            cost = '0;
        end
        if (!r_busy) begin
            cost = '0;
        end
        time_new = r_t1 + TIME_W'(cost) + TIME_W'(1);

        if (r_mode == MODE_ADMIT) begin
            we      = !r_full;
            w_addr  = r_tail;
            w_id    = r_in_pid;
            w_burst = r_in_burst;
            w_rem   = r_in_burst;
            w_arr   = r_in_arr;
            w_seen  = 1'b0;
        end else begin
            we      = r_busy;
            w_addr  = rotate ? r_tail : r_head;
            w_id    = r_h_id;
            w_burst = r_h_burst;
            w_rem   = rem_new;
            w_arr   = r_h_arr;
            w_seen  = 1'b1;
        end

        n_out = '0;
        if (r_mode == MODE_ADMIT) begin
            n_out[0]       = !r_full;
            n_out[139:108] = r_time;
        end else begin
            n_out[139:108] = time_new;
            if (r_busy) begin
                n_out[1]     = 1'b1;
                n_out[9:2]   = r_h_id;
                n_out[10]    = !r_h_seen;
                n_out[42:11] = r_h_seen ? '0 : resp;
                n_out[43]    = done;
                n_out[75:44] = done ? ta : '0;
                n_out[107:76] = done ? wait_t : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && we) begin
            r_job_ids[w_addr]    <= w_id;
            r_job_bursts[w_addr] <= w_burst;
            r_job_rem[w_addr]    <= w_rem;
            r_job_arr[w_addr]    <= w_arr;
            r_job_seen[w_addr]   <= w_seen;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_slice        <= '0;
            r_time         <= '0;
            r_restart_pend <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_mode == MODE_ADMIT) begin
                if (!r_full) begin
                    r_tail  <= next_slot(r_tail);
                    r_count <= r_count + CNT_W'(1);
                end
            end else begin
                r_time <= time_new;
                if (r_busy) begin
                    r_restart_pend <= done && last_job;
                    priority if (done) begin
                        r_head  <= next_slot(r_head);
                        r_count <= r_count - CNT_W'(1);
                        r_slice <= '0;
                    end else if (rotate) begin
                        r_head  <= next_slot(r_head);
                        r_tail  <= next_slot(r_tail);
                        r_slice <= '0;
                    end else begin
                        r_slice <= slice_new;
                    end
                end
            end
        end
    end

    assign o_data = r_out;

endmodule

>>> rtl/round_robin_cpu_scheduler_core.sv
// Each input transfer is captured, the queue head is read, then the update forms the result.
// The controller runs a capture/read/update sequence and takes a new item only after
// the update step; a result not taken stalls the update step.
// Reset: synchronous, active low; queue empty, time zero, registers at 2, 0 and 7.
// Queue slots are not cleared; the head slot is always read, but only occupied slots are used.
module round_robin_cpu_scheduler_core
    import rrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // process_id[7:0], burst_length[19:8], arrival_stamp[51:20], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // mode[0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // admit_ok[0], busy_res[1], running_pid[9:2], first_run[10], resp_latency[42:11],
    // finished[43], turnaround[75:44], wait_time[107:76], time_now[139:108], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cmd cmd;
    t_cfg cfg;

    rrs_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    rrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    rrs_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (cfg),
        .i_data  (i_s_axis_tdata),
        .i_mode  (i_s_axis_tuser),
        .o_data  (o_m_axis_tdata)
    );

endmodule

>>> rtl/rrs_checker.sv
module rrs_checker
    import rrs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped before transfer");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while an item is in flight");

    a_admit_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> !o_m_axis_tdata[1])
        else $error("admit result flags a served job");

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[43] |-> o_m_axis_tdata[1])
        else $error("completion without a served job");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind round_robin_cpu_scheduler_core rrs_checker u_rrs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .pready          (pready)
);

>>> tb/round_robin_cpu_scheduler_core_test.sv
`timescale 1ns / 1ps

module round_robin_cpu_scheduler_core_test;
    import rrs_pkg::*;

    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 110;
    localparam int HOLD_CYCLES  = 120;

    localparam logic [COST_W-1:0] PHASE_CFG [6][3] = '{
        '{8'd1,   8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd255},
        '{8'd3,   8'd17,  8'd0},
        '{8'd0,   8'd1,   8'd255},
        '{8'd255, 8'd0,   8'd7},
        '{8'd2,   8'd3,   8'd9}
    };

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] turnaround;
        logic              finished;
        logic [TIME_W-1:0] resp_latency;
        logic              first_run;
        logic [PID_W-1:0]  running_pid;
        logic              busy;
        logic              admit_ok;
    } sched_result_t;

    localparam int RES_W = $bits(sched_result_t);

    typedef struct {
        logic               mode;
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
        bit                 typed;
        sched_result_t      typed_result;
    } stim_row_t;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit            row_typed    = 1'b0;
    sched_result_t row_expected = '0;
    bit            tx_idle_on   = 1'b1;
    bit            rx_idle_on   = 1'b1;
    bit            hold_now     = 1'b0;
    int            mismatches   = 0;
    sched_result_t awaited_results[$];

    // scheduler shadow state
    logic [PID_W-1:0]   job_pid     [QUEUE_DEPTH];
    logic [BURST_W-1:0] job_need    [QUEUE_DEPTH];
    logic [BURST_W-1:0] job_left    [QUEUE_DEPTH];
    logic [TIME_W-1:0]  job_arrived [QUEUE_DEPTH];
    logic               job_started [QUEUE_DEPTH];
    int                 q_head       = 0;
    int                 q_tail       = 0;
    int                 q_count      = 0;
    logic [COST_W-1:0]  quantum_used = '0;
    logic [TIME_W-1:0]  clock_now    = '0;
    logic               restart_due  = 1'b0;
    logic [COST_W-1:0]  cfg_slice    = RST_TIME_SLICE;
    logic [COST_W-1:0]  cfg_switch   = RST_SWITCH_COST;
    logic [COST_W-1:0]  cfg_restart  = RST_RESTART_COST;

    round_robin_cpu_scheduler_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic sched_result_t sched_res(
        input logic ok, input logic busy, input logic [PID_W-1:0] pid, input logic first,
        input logic [TIME_W-1:0] resp, input logic fin, input logic [TIME_W-1:0] ta,
        input logic [TIME_W-1:0] wt, input logic [TIME_W-1:0] now);
        sched_result_t r;
        r.admit_ok      = ok;
        r.busy          = busy;
        r.running_pid   = pid;
        r.first_run     = first;
        r.resp_latency  = resp;
        r.finished      = fin;
        r.turnaround    = ta;
        r.wait_time     = wt;
        r.time_now      = now;
        return r;
    endfunction

    function automatic sched_result_t schedule_step(input logic mode,
        input logic [PID_W-1:0] pid, input logic [BURST_W-1:0] burst,
        input logic [TIME_W-1:0] arrival);
        sched_result_t r;
        int h;
        int t;
        logic [TIME_W-1:0] ta;
        r = '0;
        if (mode == MODE_ADMIT) begin
            if (q_count < QUEUE_DEPTH) begin
                t = q_tail;
                job_pid[t]     = pid;
                job_need[t]    = burst;
                job_left[t]    = burst;
                job_arrived[t] = arrival;
                job_started[t] = 1'b0;
                q_tail = (t + 1) % QUEUE_DEPTH;
                q_count++;
                r.admit_ok = 1'b1;
            end
            r.time_now = clock_now;
            return r;
        end
        if (q_count != 0) begin
            h = q_head;
            r.busy        = 1'b1;
            r.running_pid = job_pid[h];
            if (restart_due) begin
                clock_now   = clock_now + cfg_restart;
                restart_due = 1'b0;
            end
            if (!job_started[h]) begin
                job_started[h]  = 1'b1;
                r.first_run     = 1'b1;
                r.resp_latency  = clock_now - job_arrived[h];
            end
            if (job_left[h] != 0) begin
                job_left[h] = job_left[h] - 1'b1;
            end
            quantum_used = quantum_used + 1'b1;
            if (job_left[h] == 0) begin
                ta = clock_now + 1 - job_arrived[h];
                r.finished   = 1'b1;
                r.turnaround = ta;
                r.wait_time  = ta - TIME_W'(job_need[h]);
                q_head = (h + 1) % QUEUE_DEPTH;
                q_count--;
                if (q_count != 0) begin
                    clock_now = clock_now + cfg_switch;
                end else begin
                    restart_due = 1'b1;
                    clock_now   = clock_now + cfg_restart;
                end
                quantum_used = '0;
            end else if (quantum_used == cfg_slice) begin
                t = q_tail;
                if (t != h) begin
                    job_pid[t]     = job_pid[h];
                    job_need[t]    = job_need[h];
                    job_left[t]    = job_left[h];
                    job_arrived[t] = job_arrived[h];
                    job_started[t] = job_started[h];
                end
                q_head = (h + 1) % QUEUE_DEPTH;
                q_tail = (t + 1) % QUEUE_DEPTH;
                quantum_used = '0;
                clock_now = clock_now + cfg_switch;
            end
        end
        clock_now = clock_now + 1;
        r.time_now = clock_now;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
        input logic [TIME_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // predict on every input transfer, track register writes
    always @(posedge i_clk) begin
        sched_result_t predicted;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            predicted = schedule_step(i_s_axis_tuser, i_s_axis_tdata[PID_W-1:0],
                i_s_axis_tdata[PID_W+BURST_W-1:PID_W],
                i_s_axis_tdata[PID_W+BURST_W+TIME_W-1:PID_W+BURST_W]);
            awaited_results = {awaited_results, (row_typed ? row_expected : predicted)};
        end
        if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_TIME_SLICE:   cfg_slice   = pwdata[COST_W-1:0];
                REG_SWITCH_COST:  cfg_switch  = pwdata[COST_W-1:0];
                REG_RESTART_COST: cfg_restart = pwdata[COST_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        sched_result_t want;
        sched_result_t got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = sched_result_t'(o_m_axis_tdata[RES_W-1:0]);
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result expected none, got %0h", $time, o_m_axis_tdata);
            end else begin
                want = awaited_results.pop_front();
                compare_field("admit_ok", want.admit_ok, got.admit_ok);
                compare_field("busy_res", want.busy, got.busy);
                compare_field("running_pid", want.running_pid, got.running_pid);
                compare_field("first_run", want.first_run, got.first_run);
                compare_field("resp_latency", want.resp_latency, got.resp_latency);
                compare_field("finished", want.finished, got.finished);
                compare_field("turnaround", want.turnaround, got.turnaround);
                compare_field("wait_time", want.wait_time, got.wait_time);
                compare_field("time_now", want.time_now, got.time_now);
                compare_field("tdata pad", '0, o_m_axis_tdata[OUT_DATA_W-1:RES_W]);
            end
        end
    end

    task automatic reg_access(input bit is_write, input logic [1:0] idx,
        input logic [COST_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (!is_write) begin
            compare_field("register read", APB_DATA_W'(val), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic mode, input logic [PID_W-1:0] pid,
        input logic [BURST_W-1:0] burst, input logic [TIME_W-1:0] arrival,
        input bit typed, input sched_result_t typed_result);
        if (tx_idle_on && $urandom_range(0, 6) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= IN_DATA_W'({arrival, burst, pid});
        row_typed       <= typed;
        row_expected    <= typed_result;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    initial begin
        int stall;
        forever begin
            if (hold_now) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_now = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 18);
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        stim_row_t          directed_rows[$];
        logic [COST_W-1:0]  slice;
        logic [COST_W-1:0]  sw_cost;
        logic [COST_W-1:0]  rs_cost;
        logic               mode;
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
        int                 admit_pct;
        int                 sel;

        directed_rows = '{
            '{MODE_TICK,  8'h00, 12'd0,   32'h0,        1'b1,
                sched_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 1)},
            '{MODE_ADMIT, 8'hff, 12'd0,   32'h0,        1'b1,
                sched_res(1, 0, 8'h00, 0, 0, 0, 0, 0, 1)},
            '{MODE_TICK,  8'h5a, 12'ha5a, 32'hdeadbeef, 1'b1,
                sched_res(0, 1, 8'hff, 1, 1, 1, 2, 2, 9)},
            '{MODE_ADMIT, 8'h00, 12'hfff, 32'hffffffff, 1'b1,
                sched_res(1, 0, 8'h00, 0, 0, 0, 0, 0, 9)},
            '{MODE_TICK,  8'h00, 12'd0,   32'h0,        1'b1,
                sched_res(0, 1, 8'h00, 1, 17, 0, 0, 0, 17)},
            '{MODE_ADMIT, 8'h01, 12'd1,   32'd0,  1'b0, '0},
            '{MODE_ADMIT, 8'h02, 12'd2,   32'd1,  1'b0, '0},
            '{MODE_ADMIT, 8'h03, 12'd3,   32'd2,  1'b0, '0},
            '{MODE_ADMIT, 8'h04, 12'd1,   32'd3,  1'b0, '0},
            '{MODE_ADMIT, 8'h05, 12'd2,   32'd4,  1'b0, '0},
            '{MODE_ADMIT, 8'h06, 12'd3,   32'd5,  1'b0, '0},
            '{MODE_ADMIT, 8'h07, 12'd1,   32'd6,  1'b0, '0},
            '{MODE_ADMIT, 8'h08, 12'd2,   32'd7,  1'b0, '0},
            '{MODE_ADMIT, 8'h09, 12'd3,   32'd8,  1'b0, '0},
            '{MODE_ADMIT, 8'h0a, 12'd1,   32'd9,  1'b0, '0},
            '{MODE_ADMIT, 8'h0b, 12'd2,   32'd10, 1'b0, '0},
            '{MODE_ADMIT, 8'h0c, 12'd3,   32'd11, 1'b0, '0},
            '{MODE_ADMIT, 8'h0d, 12'd1,   32'd12, 1'b0, '0},
            '{MODE_ADMIT, 8'h0e, 12'd2,   32'd13, 1'b0, '0},
            '{MODE_ADMIT, 8'h0f, 12'd3,   32'd17, 1'b0, '0},
            '{MODE_ADMIT, 8'h10, 12'd1,   32'd3,        1'b1,
                sched_res(0, 0, 8'h00, 0, 0, 0, 0, 0, 17)},
            '{MODE_TICK,  8'hff, 12'hfff, 32'hffffffff, 1'b0, '0},
            '{MODE_TICK,  8'h00, 12'd0,   32'h0,        1'b0, '0},
            '{MODE_TICK,  8'ha5, 12'h5a5, 32'h12345678, 1'b0, '0},
            '{MODE_TICK,  8'h00, 12'd0,   32'h0,        1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reg_access(1'b0, REG_TIME_SLICE, RST_TIME_SLICE);
        reg_access(1'b0, REG_SWITCH_COST, RST_SWITCH_COST);
        reg_access(1'b0, REG_RESTART_COST, RST_RESTART_COST);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].mode, directed_rows[i].pid, directed_rows[i].burst,
                directed_rows[i].arrival, directed_rows[i].typed,
                directed_rows[i].typed_result);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (p < 6) begin
                slice   = PHASE_CFG[p][0];
                sw_cost = PHASE_CFG[p][1];
                rs_cost = PHASE_CFG[p][2];
            end else begin
                slice   = COST_W'($urandom_range(1, 6));
                sw_cost = COST_W'($urandom);
                rs_cost = COST_W'($urandom);
            end
            reg_access(1'b1, REG_TIME_SLICE, slice);
            reg_access(1'b1, REG_SWITCH_COST, sw_cost);
            reg_access(1'b1, REG_RESTART_COST, rs_cost);
            reg_access(1'b0, REG_TIME_SLICE, slice);
            reg_access(1'b0, REG_SWITCH_COST, sw_cost);
            reg_access(1'b0, REG_RESTART_COST, rs_cost);

            tx_idle_on = (p != PHASES - 1) && (p != 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (p == 1) begin
                hold_now = 1'b1;
            end
            admit_pct = $urandom_range(30, 60);

            repeat (PHASE_ITEMS) begin
                mode = ($urandom_range(1, 100) <= admit_pct) ? MODE_ADMIT : MODE_TICK;
                pid  = PID_W'($urandom);
                sel  = $urandom_range(0, 99);
                if (sel < 5) begin
                    burst = '0;
                end else if (sel < 85) begin
                    burst = BURST_W'($urandom_range(1, 6));
                end else if (sel < 99) begin
                    burst = BURST_W'($urandom_range(7, 64));
                end else begin
                    burst = BURST_W'($urandom);
                end
                if ($urandom_range(0, 7) == 0) begin
                    arrival = $urandom;
                end else begin
                    arrival = $urandom_range(0, clock_now);
                end
                send_item(mode, pid, burst, arrival, 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("round_robin_cpu_scheduler_core: match");
        end else begin
            $display("round_robin_cpu_scheduler_core: mismatch");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("round_robin_cpu_scheduler_core: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/rrs_pkg.sv
rtl/rrs_cfg_regs.sv
rtl/rrs_ctrl.sv
rtl/rrs_dp.sv
rtl/round_robin_cpu_scheduler_core.sv
rtl/rrs_checker.sv
tb/round_robin_cpu_scheduler_core_test.sv
